@@ design/scfd_pkg.sv @@
// Shared types, constants and CRC helpers for the salted CRC-8 frame deframer.
package scfd_pkg;

    localparam logic [7:0] CRC_POLY   = 8'hD5;
    localparam int         KEY_W      = 32;
    localparam int         LEN_TBL_W  = 64;
    localparam int         CFG_DATA_W = 64;
    localparam int         CFG_IDX_W  = 1;
    localparam int         BYTE_W     = 8;
    localparam int         INDEX_W    = 5;
    localparam int         NIBBLE_W   = 4;
    localparam int         KIND_W     = 3;
    localparam int         OUT_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIND_KEY  = 1'b0,
        CFG_LEN_TABLE = 1'b1
    } t_cfg_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_HEADER   = 3'd0,
        KIND_PAYLOAD  = 3'd1,
        KIND_GOOD     = 3'd2,
        KIND_BAD      = 3'd3,
        KIND_OVERFLOW = 3'd4
    } t_kind;

    typedef logic [7:0] t_key_cols [KEY_W];

    // One byte through CRC-8, MSB first.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

    // CRC of the four key bytes for each single set key bit; the CRC is linear.
    function automatic t_key_cols key_cols();
        t_key_cols  cols;
        logic [KEY_W-1:0] w;
        logic [7:0] c;
        for (int j = 0; j < KEY_W; j++) begin
            w = KEY_W'(1) << j;
            c = 8'h00;
            for (int k = 0; k < KEY_W / 8; k++) begin
                c = crc8_byte(c, w[8*k +: 8]);
            end
            cols[j] = c;
        end
        return cols;
    endfunction

    localparam t_key_cols KEY_COLS = key_cols();

    // Salt CRC of a bind key: XOR of the columns of its set bits.
    function automatic logic [7:0] salt_of(input logic [KEY_W-1:0] key);
        logic [7:0] s;
        s = 8'h00;
        for (int j = 0; j < KEY_W; j++) begin
            if (key[j]) begin
                s = s ^ KEY_COLS[j];
            end
        end
        return s;
    endfunction

endpackage

@@ design/salted_crc8_frame_deframer.sv @@
// Salted CRC-8 frame deframer: header, payload and CRC byte decode, one result per byte.
//
//  Channel   | Dir | Handshake                     | Payload
//  ----------+-----+-------------------------------+-----------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata[7:0] rx_byte
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata byte_value, byte_index, frame_type,
//            |     |                               | link_channel; tuser result_kind
//  cfg       | in  | i_cfg_we (no wait)            | i_cfg_idx, i_cfg_wdata
//
// One beat in per cycle while s_axis_tready is high; the byte CRC update
// and decode sit between the phase registers and the output register.
// The salt CRC of the bind key is folded into a register when the key is written.
// i_rst_n (synchronous) returns the decoder to idle and clears the salt and length table.
// s_axis_tready drops only while a result waits and m_axis_tready is low.
module salted_crc8_frame_deframer #(
    parameter int MAX_PAYLOAD = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [scfd_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] rx_byte
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [7:0] byte_value, [12:8] byte_index, [16:13] frame_type, [20:17] link_channel
    output logic [scfd_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    output logic [scfd_pkg::KIND_W-1:0]       m_axis_tuser,   // [2:0] result_kind
    input  logic                              i_cfg_we,
    input  logic [scfd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [scfd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1);
    localparam int CMP_W = CNT_W + 5;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_CRC     = 2'd2
    } t_phase;

    t_phase                              r_phase, n_phase;
    logic [7:0]                          r_crc, n_crc;
    logic [scfd_pkg::NIBBLE_W-1:0]       r_exp_len, n_exp_len;
    logic [CNT_W-1:0]                    r_count, n_count;
    logic [scfd_pkg::NIBBLE_W-1:0]       r_ftype, n_ftype;
    logic [scfd_pkg::NIBBLE_W-1:0]       r_chan, n_chan;
    logic [7:0]                          r_salt;
    logic [scfd_pkg::LEN_TBL_W-1:0]      r_len_tbl;

    logic                                r_out_valid;
    scfd_pkg::t_kind                     r_out_kind, n_out_kind;
    logic [7:0]                          r_out_byte, n_out_byte;
    logic [scfd_pkg::INDEX_W-1:0]        r_out_index, n_out_index;

    logic                                accept;
    logic [7:0]                          rx;
    logic [CNT_W:0]                      cnt_inc;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign rx            = s_axis_tdata;
    assign cnt_inc       = {1'b0, r_count} + (CNT_W + 1)'(1);

    always_comb begin
        n_phase     = r_phase;
        n_crc       = r_crc;
        n_exp_len   = r_exp_len;
        n_count     = r_count;
        n_ftype     = r_ftype;
        n_chan      = r_chan;
        n_out_kind  = scfd_pkg::KIND_HEADER;
        n_out_byte  = 8'h00;
        n_out_index = '0;
        unique case (r_phase)
            PH_PAYLOAD: begin
                if (r_count >= CNT_W'(MAX_PAYLOAD)) begin
                    // abort the frame rather than store past the payload limit
                    n_phase    = PH_IDLE;
                    n_out_kind = scfd_pkg::KIND_OVERFLOW;
                    n_out_byte = rx;
                end else begin
                    n_crc       = scfd_pkg::crc8_byte(r_crc, rx);
                    n_out_kind  = scfd_pkg::KIND_PAYLOAD;
                    n_out_byte  = rx;
                    n_out_index = scfd_pkg::INDEX_W'(r_count);
                    n_count     = cnt_inc[CNT_W-1:0];
                    if (CMP_W'(cnt_inc) == CMP_W'(r_exp_len)) begin
                        n_phase = PH_CRC;
                    end
                end
            end
            PH_CRC: begin
                n_out_kind = (r_crc == rx) ? scfd_pkg::KIND_GOOD : scfd_pkg::KIND_BAD;
                n_out_byte = rx;
                n_phase    = PH_IDLE;
            end
            default: begin
                // header byte; the unused phase code behaves as idle
                n_crc     = scfd_pkg::crc8_byte(r_salt, rx);
                n_ftype   = rx[7:4];
                n_chan    = rx[3:0];
                n_exp_len = r_len_tbl[{rx[7:4], 2'b00} +: scfd_pkg::NIBBLE_W];
                n_count   = '0;
                n_phase   = PH_PAYLOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_crc       <= 8'h00;
            r_exp_len   <= '0;
            r_count     <= '0;
            r_ftype     <= '0;
            r_chan      <= '0;
            r_salt      <= 8'h00;
            r_len_tbl   <= '0;
            r_out_valid <= 1'b0;
            r_out_kind  <= scfd_pkg::KIND_HEADER;
            r_out_byte  <= 8'h00;
            r_out_index <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (scfd_pkg::t_cfg_idx'(i_cfg_idx))
                    scfd_pkg::CFG_BIND_KEY:
                        r_salt <= scfd_pkg::salt_of(i_cfg_wdata[scfd_pkg::KEY_W-1:0]);
                    scfd_pkg::CFG_LEN_TABLE:
                        r_len_tbl <= i_cfg_wdata[scfd_pkg::LEN_TBL_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_phase     <= n_phase;
                r_crc       <= n_crc;
                r_exp_len   <= n_exp_len;
                r_count     <= n_count;
                r_ftype     <= n_ftype;
                r_chan      <= n_chan;
                r_out_valid <= 1'b1;
                r_out_kind  <= n_out_kind;
                r_out_byte  <= n_out_byte;
                r_out_index <= n_out_index;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {3'b000, r_chan, r_ftype, r_out_index, r_out_byte};

    // the count never runs past the payload limit
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_PAYLOAD))
        else $error("payload count beyond limit");

    // a header beat opens the payload phase
    a_header_to_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_phase != PH_PAYLOAD && r_phase != PH_CRC |=> r_phase == PH_PAYLOAD)
        else $error("header did not open payload phase");

    // a CRC beat closes the frame
    a_crc_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && r_phase == PH_CRC |=> r_phase == PH_IDLE
            && (r_out_kind == scfd_pkg::KIND_GOOD || r_out_kind == scfd_pkg::KIND_BAD))
        else $error("CRC beat did not close the frame");

    // a payload result carries an index below the payload limit
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == scfd_pkg::KIND_PAYLOAD
            |-> (CMP_W'(r_out_index) < CMP_W'(MAX_PAYLOAD)))
        else $error("payload index beyond limit");

endmodule
